// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the core RTL.
// Depends on nothing; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/mlap_pkg.sv =====
// Types and constants of the masked absolute Laplacian core.
// Depends on nothing; imported by the core top level.
package mlap_pkg;

    localparam int PIX_W          = 8;
    localparam int LAP_W          = 10;
    localparam int ROW_W          = 16;
    localparam int IMG_WIDTH_W    = 12;
    localparam int IMG_HEIGHT_W   = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int DEF_MAX_WIDTH  = 2048;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RESET  = 12'd640;
    localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RESET = 16'd480;

    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] pixel;
        logic             mask_bit;
    } mlap_in_t;

    typedef struct packed {
        logic [LAP_W-1:0] lap_value;
        logic             frame_end;
    } mlap_out_t;

endpackage

// ===== rtl/core/mlap_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing; read returns the old data on a same-address write.
module mlap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/masked_abs_laplacian_core.sv =====
// Top level of the masked absolute four-neighbour Laplacian core.
// Depends on mlap_pkg, mlap_ram and assert_macros.svh.
//
//  channel | signals                          | beat
//  --------+----------------------------------+-------------------------------
//  pix     | pix_valid pix_stall pix_data     | push or drain item
//  lap     | lap_valid lap_stall lap_data     | Laplacian result, frame_end
//  cfg     | cfg_we cfg_index cfg_wdata       | register write, no wait
//
// One item per cycle unless stalled; results are registered, out in the next cycle.
// The line stores are RAMs read at the next column count (the centre line one beyond),
// so the stencil window is ready on every cycle without bubbles, row wraps included.
// pix_stall follows lap_stall while a result is held.
// Reset clears counters and result valid, presets sizes; line stores keep no reset.
`include "assert_macros.svh"

module masked_abs_laplacian_core
    import mlap_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  mlap_in_t              pix_data,
    output logic                  lap_valid,
    input  logic                  lap_stall,
    output mlap_out_t             lap_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WEXT_W = (COL_W + 1 > IMG_WIDTH_W) ? COL_W + 1 : IMG_WIDTH_W;

    logic [IMG_WIDTH_W-1:0]  img_width_reg, img_width_next;
    logic [IMG_HEIGHT_W-1:0] img_height_reg, img_height_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic                    out_vld_reg, out_vld_next;
    mlap_out_t               out_data_reg, out_data_next;

    logic [PIX_W-1:0]        x_reg, x_next;
    logic [PIX_W-1:0]        w_reg, w_next;
    logic [PIX_W-1:0]        first_pix_reg, first_pix_next;
    logic [PIX_W-1:0]        second_pix_reg, second_pix_next;

    logic [WEXT_W-1:0]       w_ext;
    logic [COL_W-1:0]        last_col;
    logic [ROW_W-1:0]        h_eff;

    logic                    pix_accept;
    logic                    drain_item;
    logic                    draining;
    logic                    at_first;
    logic                    at_last;
    logic                    push_ok;
    logic                    drain_ok;
    logic                    step;
    logic                    emit;
    logic                    cfg_restart;

    logic [PIX_W-1:0]        upper_q;
    logic [PIX_W-1:0]        center_q;
    logic                    mask_q;
    logic [PIX_W-1:0]        e_cur;
    logic [PIX_W-1:0]        n_val, s_val, e_val, w_val;
    logic [LAP_W-1:0]        pos, neg, lap;
    logic                    ram_we;
    logic [COL_W-1:0]        center_raddr;

    // effective frame size
    assign w_ext = WEXT_W'(img_width_reg);

    always_comb
    begin
        if (w_ext < WEXT_W'(2))
        begin
            last_col = COL_W'(1);
        end
        else if (w_ext > WEXT_W'(MAX_WIDTH))
        begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = COL_W'(w_ext - WEXT_W'(1));
        end
    end

    assign h_eff = (img_height_reg < ROW_W'(2)) ? ROW_W'(2) : img_height_reg;

    // handshake and item decode
    assign pix_stall  = out_vld_reg & lap_stall;
    assign pix_accept = pix_valid & ~pix_stall;
    assign drain_item = (pix_data.func == FUNC_DRAIN);
    assign draining   = (row_reg >= h_eff);
    assign at_first   = (col_reg == '0);
    assign at_last    = (col_reg == last_col);
    assign push_ok    = ~drain_item & ~draining;
    assign drain_ok   = drain_item & draining;
    assign step       = pix_accept & (push_ok | drain_ok);
    assign emit       = push_ok ? (row_reg != '0) : drain_ok;
    assign cfg_restart = cfg_we
                       & ((cfg_index == CFG_IMAGE_WIDTH) | (cfg_index == CFG_IMAGE_HEIGHT));

    // stencil
    assign e_cur = at_first ? second_pix_reg : center_q;
    assign n_val = (drain_item | (row_reg >= ROW_W'(2))) ? upper_q : pix_data.pixel;
    assign s_val = drain_item ? upper_q : pix_data.pixel;
    assign w_val = at_first ? e_cur : w_reg;
    assign e_val = at_last ? w_reg : e_cur;
    assign pos   = {x_reg, 2'b00};
    assign neg   = LAP_W'(n_val) + LAP_W'(s_val) + LAP_W'(e_val) + LAP_W'(w_val);
    assign lap   = (pos >= neg) ? (pos - neg) : (neg - pos);

    always_comb
    begin
        img_width_next  = img_width_reg;
        img_height_next = img_height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  img_width_next  = cfg_wdata[IMG_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: img_height_next = cfg_wdata[IMG_HEIGHT_W-1:0];
                default:          img_width_next  = img_width_reg;
            endcase
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (step)
        begin
            if (at_last)
            begin
                col_next = '0;
                row_next = drain_item ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
        if (cfg_restart)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_comb
    begin
        x_next          = x_reg;
        w_next          = w_reg;
        first_pix_next  = first_pix_reg;
        second_pix_next = second_pix_reg;
        if (step)
        begin
            w_next = x_reg;
            x_next = at_last ? first_pix_reg : e_cur;
        end
        if (pix_accept & push_ok & at_first)
        begin
            first_pix_next = pix_data.pixel;
        end
        if (pix_accept & push_ok & (col_reg == COL_W'(1)))
        begin
            second_pix_next = pix_data.pixel;
        end
    end

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        if (!pix_stall)
        begin
            out_vld_next            = pix_accept & emit;
            out_data_next.lap_value = mask_q ? lap : '0;
            out_data_next.frame_end = drain_ok & at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_width_reg  <= IMG_WIDTH_RESET;
            img_height_reg <= IMG_HEIGHT_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            img_width_reg  <= img_width_next;
            img_height_reg <= img_height_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        x_reg          <= x_next;
        w_reg          <= w_next;
        first_pix_reg  <= first_pix_next;
        second_pix_reg <= second_pix_next;
    end

    assign lap_valid = out_vld_reg;
    assign lap_data  = out_data_reg;

    // line stores, read at the next column count (centre line one beyond)
    assign ram_we       = pix_accept & push_ok;
    assign center_raddr = col_next + COL_W'(1);

    mlap_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (x_reg),
        .raddr (col_next),
        .rdata (upper_q)
    );

    mlap_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_center_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (pix_data.pixel),
        .raddr (center_raddr),
        .rdata (center_q)
    );

    mlap_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_center_mask_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (pix_data.mask_bit),
        .raddr (col_next),
        .rdata (mask_q)
    );

    `ASSERT_IMPL(a_col_range, clk, rst_n, 1'b1, col_reg <= last_col)
    `ASSERT_IMPL(a_row_range, clk, rst_n, 1'b1, row_reg <= h_eff)
    `ASSERT_IMPL(a_res_cause, clk, rst_n, $rose(out_vld_reg), $past(pix_accept))
    `ASSERT_NEXT(a_frame_wrap, clk, rst_n, step && drain_item && at_last,
                 (row_reg == '0) && (col_reg == '0))

endmodule

// ===== tb/sv/masked_abs_laplacian_core_test.sv =====
// Self-checking testbench for masked_abs_laplacian_core: random frames, predicted results.
// Depends on mlap_pkg and the core RTL; a scoreboard class tracks the line stores and counters.
`timescale 1ns / 1ps

module masked_abs_laplacian_core_test;
    import mlap_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned RANDOM_BEATS     = 1050;
    localparam int unsigned SETTLE_CYCLES    = 8;

    class lap_scoreboard;
        bit [PIX_W-1:0]        north_row [DEF_MAX_WIDTH];
        bit [PIX_W-1:0]        mid_row [DEF_MAX_WIDTH];
        bit                    mid_mask [DEF_MAX_WIDTH];
        bit [IMG_WIDTH_W-1:0]  width_reg = IMG_WIDTH_RESET;
        bit [IMG_HEIGHT_W-1:0] height_reg = IMG_HEIGHT_RESET;
        int unsigned           col = 0;
        int unsigned           row = 0;
        mlap_out_t             expected_laps[$];
        int unsigned           fail_count = 0;

        function int unsigned active_width();
            int unsigned w;
            w = width_reg;
            if (w < 2) w = 2;
            if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
            return w;
        endfunction

        function int unsigned active_height();
            return (height_reg < 2) ? 2 : height_reg;
        endfunction

        function int pending();
            return expected_laps.size();
        endfunction

        function logic [LAP_W-1:0] abs_laplace(int unsigned centre, int unsigned nb_sum);
            int unsigned pos;
            pos = centre << 2;
            return LAP_W'((pos >= nb_sum) ? pos - nb_sum : nb_sum - pos);
        endfunction

        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_IMAGE_WIDTH)
                width_reg = value[IMG_WIDTH_W-1:0];
            else if (idx == CFG_IMAGE_HEIGHT)
                height_reg = value[IMG_HEIGHT_W-1:0];
            else
                return;
            col = 0;
            row = 0;
        endfunction

        function void note_pixel_beat(mlap_in_t beat);
            int unsigned wd, ht, c, x, n, s, e, w;
            bit          m, emit;
            mlap_out_t   res;
            wd = active_width();
            ht = active_height();
            c = col;
            if (c >= wd) c = wd - 1;
            if (beat.func == FUNC_PUSH)
            begin
                if (row >= ht) return;
                emit = (row >= 1);
                x = mid_row[c];
                m = mid_mask[c];
                n = (row >= 2) ? north_row[c] : beat.pixel;
                s = beat.pixel;
                north_row[c] = mid_row[c];
                mid_row[c] = beat.pixel;
                mid_mask[c] = beat.mask_bit;
                if (c == 0)
                begin
                    w = mid_row[1];
                    e = w;
                end
                else if (c == wd - 1)
                begin
                    w = north_row[c-1];
                    e = w;
                end
                else
                begin
                    w = north_row[c-1];
                    e = mid_row[c+1];
                end
                if (c + 1 >= wd)
                begin
                    col = 0;
                    row = row + 1;
                end
                else
                begin
                    col = c + 1;
                end
                if (!emit) return;
                res.lap_value = m ? abs_laplace(x, n + s + e + w) : '0;
                res.frame_end = 1'b0;
            end
            else
            begin
                if (row < ht) return;
                x = mid_row[c];
                m = mid_mask[c];
                n = north_row[c];
                s = n;
                if (c == 0)
                begin
                    w = mid_row[1];
                    e = w;
                end
                else if (c == wd - 1)
                begin
                    w = mid_row[c-1];
                    e = w;
                end
                else
                begin
                    w = mid_row[c-1];
                    e = mid_row[c+1];
                end
                res.lap_value = m ? abs_laplace(x, n + s + e + w) : '0;
                if (c + 1 >= wd)
                begin
                    res.frame_end = 1'b1;
                    col = 0;
                    row = 0;
                end
                else
                begin
                    res.frame_end = 1'b0;
                    col = c + 1;
                end
            end
            expected_laps.push_back(res);
        endfunction

        function void check_lap_beat(mlap_out_t got);
            mlap_out_t want;
            if (expected_laps.size() == 0)
            begin
                $error("unexpected result: lap_value %0d frame_end %0d",
                       got.lap_value, got.frame_end);
                fail_count++;
                return;
            end
            want = expected_laps.pop_front();
            if (got.lap_value !== want.lap_value)
            begin
                $error("lap_value: expected %0d, got %0d", want.lap_value, got.lap_value);
                fail_count++;
            end
            if (got.frame_end !== want.frame_end)
            begin
                $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
                fail_count++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  pix_valid = 1'b0;
    logic                  pix_stall;
    mlap_in_t              pix_data = '0;
    logic                  lap_valid;
    logic                  lap_stall = 1'b0;
    mlap_out_t             lap_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    lap_scoreboard sb = new;
    bit            no_idle = 1'b0;
    bit            long_hold_req = 1'b0;
    bit            long_hold_active = 1'b0;
    int unsigned   counted_beats = 0;

    masked_abs_laplacian_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .lap_valid (lap_valid),
        .lap_stall (lap_stall),
        .lap_data  (lap_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    function automatic int unsigned pick_stall();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic mlap_in_t make_item(logic f, logic [PIX_W-1:0] p, logic mb);
        mlap_in_t it;
        it.func = f;
        it.pixel = p;
        it.mask_bit = mb;
        return it;
    endfunction

    task automatic send_beat(input mlap_in_t item);
        int unsigned gap;
        gap = pick_gap();
        repeat (gap)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data <= item;
        do
            @(posedge clk);
        while (pix_stall);
        sb.note_pixel_beat(item);
    endtask

    task automatic settle();
        pix_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.apply_register(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_frame(input int unsigned cut_at);
        int unsigned wd, ht, pushes, total, k;
        mlap_in_t    item;
        wd = sb.active_width();
        ht = sb.active_height();
        pushes = wd * ht;
        total = pushes + wd;
        if (cut_at < total) total = cut_at;
        for (k = 0; k < total; k++)
        begin
            // drop in an off-phase item now and then
            if ($urandom_range(0, 19) == 0)
                send_beat(make_item((k < pushes) ? FUNC_DRAIN : FUNC_PUSH,
                                    random_pixel(), 1'($urandom_range(0, 1))));
            if (k < pushes)
                item = make_item(FUNC_PUSH, random_pixel(), $urandom_range(0, 3) != 0);
            else
                item = make_item(FUNC_DRAIN, random_pixel(), 1'($urandom_range(0, 1)));
            send_beat(item);
            counted_beats++;
        end
    endtask

    task automatic random_phase();
        int unsigned           r, wd, ht, total;
        logic [CFG_DATA_W-1:0] wv, hv;
        settle();
        no_idle = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 9);
        if (r == 0) wd = $urandom_range(0, 1);
        else if (r < 8) wd = $urandom_range(2, 8);
        else wd = $urandom_range(9, 40);
        r = $urandom_range(0, 9);
        if (r == 0) ht = $urandom_range(0, 1);
        else if (r < 8) ht = $urandom_range(2, 4);
        else ht = $urandom_range(5, 8);
        wv = CFG_DATA_W'(wd);
        if ($urandom_range(0, 3) == 0)
            wv[CFG_DATA_W-1:IMG_WIDTH_W] = (CFG_DATA_W-IMG_WIDTH_W)'($urandom);
        hv = CFG_DATA_W'(ht);
        r = $urandom_range(0, 4);
        if (r == 0)
        begin
            write_register(CFG_IMAGE_WIDTH, wv);
        end
        else if (r == 1)
        begin
            write_register(CFG_IMAGE_HEIGHT, hv);
        end
        else if (r == 2)
        begin
            write_register(CFG_IMAGE_HEIGHT, hv);
            write_register(CFG_IMAGE_WIDTH, wv);
        end
        else
        begin
            write_register(CFG_IMAGE_WIDTH, wv);
            write_register(CFG_IMAGE_HEIGHT, hv);
        end
        total = sb.active_width() * (sb.active_height() + 1);
        if ($urandom_range(0, 6) == 0)
            run_frame($urandom_range(1, total - 1));
        else
            run_frame(total);
        if ($urandom_range(0, 7) == 0)
            send_beat(make_item(FUNC_DRAIN, random_pixel(), 1'b1));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && lap_valid && !lap_stall)
            sb.check_lap_beat(lap_data);
    end

    initial
    begin
        int unsigned len;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_active = 1'b1;
                repeat (LONG_HOLD_CYCLES)
                begin
                    lap_stall <= 1'b1;
                    @(posedge clk);
                end
                long_hold_active = 1'b0;
                long_hold_req = 1'b0;
            end
            len = pick_stall();
            repeat (len)
            begin
                lap_stall <= 1'b1;
                @(posedge clk);
            end
            len = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
            repeat (len)
            begin
                lap_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #25_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int unsigned k;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest frame, both registers below their floor
        write_register(CFG_IMAGE_WIDTH, 16'd1);
        write_register(CFG_IMAGE_HEIGHT, 16'd0);
        send_beat(make_item(FUNC_DRAIN, 8'hFF, 1'b1));
        send_beat(make_item(FUNC_PUSH, 8'hFF, 1'b1));
        send_beat(make_item(FUNC_PUSH, 8'h00, 1'b1));
        send_beat(make_item(FUNC_PUSH, 8'h00, 1'b1));
        send_beat(make_item(FUNC_PUSH, 8'hFF, 1'b0));
        send_beat(make_item(FUNC_PUSH, 8'h5A, 1'b1));
        send_beat(make_item(FUNC_DRAIN, 8'h00, 1'b0));
        send_beat(make_item(FUNC_DRAIN, 8'hFF, 1'b1));
        send_beat(make_item(FUNC_DRAIN, 8'hA5, 1'b1));
        settle();

        // 3x3 with writes to unmapped indexes mid-frame
        write_register(CFG_IMAGE_WIDTH, 16'd3);
        write_register(CFG_IMAGE_HEIGHT, 16'd3);
        for (k = 0; k < 12; k++)
        begin
            if (k == 6)
            begin
                settle();
                write_register(CFG_UNMAPPED_A, 16'hFFFF);
                write_register(CFG_UNMAPPED_B, 16'h0000);
            end
            send_beat(make_item((k < 9) ? FUNC_PUSH : FUNC_DRAIN, random_pixel(), k != 4));
        end
        settle();

        // tallest frame: a few rows only, then restart
        write_register(CFG_IMAGE_HEIGHT, 16'hFFFF);
        repeat (9) send_beat(make_item(FUNC_PUSH, random_pixel(), 1'b1));
        settle();

        // receiver holds off for a long stretch to back up the input
        write_register(CFG_IMAGE_WIDTH, 16'd32);
        write_register(CFG_IMAGE_HEIGHT, 16'd2);
        long_hold_req = 1'b1;
        wait (long_hold_active);
        run_frame(sb.active_width() * 3);

        counted_beats = 0;
        while (counted_beats < RANDOM_BEATS)
            random_phase();

        settle();
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
